// File: design/sse_pkg.sv
// Shared types and constants for the signature section extractor.
// No dependencies; imported by every module of the block.
package sse_pkg;

  localparam int SIG_BYTES_MAX   = 16;
  localparam int HDR_FIELD_BYTES = 4;
  localparam int SIZE_W          = 8 * HDR_FIELD_BYTES;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_LOW  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_HIGH = 1'd1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic [1:0] ST_EXTRACTED = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic              last;
    logic [1:0]        status;
    logic [SIZE_W-1:0] used_size;
    logic [SIZE_W-1:0] full_size;
  } result_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } push_t;

endpackage

// File: design/sse_cell.sv
// One window cell: holds a past image byte and its valid flag, compares it
// against its signature byte and hands both to the next cell. Uses sse_pkg.
module sse_cell
  import sse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clear,
  input  logic [7:0] byte_in,
  input  logic       valid_in,
  input  logic [7:0] sig_byte,
  output logic [7:0] byte_out,
  output logic       valid_out,
  output logic       hit
);

  logic [7:0] byte_r;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= valid_in;
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;
  assign hit       = valid_r && (byte_r == sig_byte);

endmodule

// File: design/sse_result_fifo.sv
// Result queue: takes up to two result transactions per cycle, hands out one.
// Uses sse_pkg for result_t, push_t and the queue depth.
module sse_result_fifo
  import sse_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  result_t wr_a,
  input  result_t wr_b,
  input  logic    pop,
  output logic    room2,
  output logic    not_empty,
  output result_t head
);

  result_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr_r;
  logic [FIFO_AW-1:0]  wr_ptr_nxt;
  logic [FIFO_AW-1:0]  rd_ptr_r;
  logic [FIFO_AW-1:0]  rd_ptr_nxt;
  logic [FIFO_CW-1:0]  count_r;
  logic [FIFO_CW-1:0]  count_nxt;
  logic [FIFO_AW-1:0]  wr_ptr_b;

  assign wr_ptr_b = wr_ptr_r + FIFO_AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.a_valid) + FIFO_AW'(push.b_valid);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + FIFO_CW'(push.a_valid) + FIFO_CW'(push.b_valid)
                 - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      mem_r[wr_ptr_r] <= wr_a;
    end
    if (push.b_valid) begin
      mem_r[wr_ptr_b] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign room2     = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

endmodule

// File: design/signature_section_extractor.sv
// Top level of the signature section extractor: window cell chain, header
// and payload sequencing, result queue. Uses sse_pkg, sse_cell, sse_result_fifo.
//
//   channel  direction  payload
//   in_      slave      tdata[7:0] image byte, tlast image end
//   out_     master     tuser item kind, tdata sizes/status/byte, tlast last
//   cfg_     write      cfg_index selects signature_low / signature_high
//
// One image byte per cycle while in_tready is high; a result is queued on the
// transaction that causes it. The match is a single compare across the chain
// of SIGNATURE_LENGTH-1 window cells plus the incoming byte. in_tready falls
// while the four-entry result queue holds more than two results.
// Synchronous reset clears the signature, the window, the sequencer and queue.
module signature_section_extractor
  import sse_pkg::*;
#(
  parameter int SIGNATURE_LENGTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] image_byte
  input  logic                   in_tlast,   // image_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [79:0]            out_tdata,  // [7:0] payload_byte, [9:8] status,
                                             // [41:10] declared_used_size,
                                             // [73:42] declared_full_size
  output logic                   out_tlast,  // payload_last
  output logic                   out_tuser,  // [0] item_kind
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NCELL = (SIGNATURE_LENGTH > 1) ? SIGNATURE_LENGTH - 1 : 1;

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  logic [CFG_DATA_W-1:0] sig_low_r;
  logic [CFG_DATA_W-1:0] sig_high_r;
  logic [127:0]          sig_all;

  logic [1:0]        phase_r, phase_nxt;
  logic [2:0]        hdr_r, hdr_nxt;
  logic [SIZE_W-1:0] full_r, full_nxt;
  logic [SIZE_W-1:0] used_r, used_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;

  logic             in_fire;
  logic             end_fire;
  logic             win_shift;
  logic [NCELL-1:0] cell_hit;
  logic             sig_match;
  logic             pay_valid;
  logic             pay_last;
  logic [1:0]       rpt_status;

  result_t pay_item;
  result_t rpt_item;
  result_t wr_a;
  result_t wr_b;
  result_t head;
  push_t   push;
  logic    room2;
  logic    q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_low_r  <= '0;
      sig_high_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SIG_LOW:  sig_low_r  <= cfg_wdata;
        REG_SIG_HIGH: sig_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sig_all  = {sig_high_r, sig_low_r};
  assign in_fire  = in_tvalid && in_tready;
  assign end_fire = in_fire && in_tlast;

  generate
    if (SIGNATURE_LENGTH > 1) begin : g_chain
      logic [7:0] chain_byte [NCELL+1];
      logic       chain_vld  [NCELL+1];

      assign chain_byte[0] = in_tdata;
      assign chain_vld[0]  = 1'b1;

      for (genvar i = 0; i < NCELL; i++) begin : g_cell
        sse_cell u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .shift_en  (win_shift),
          .clear     (end_fire),
          .byte_in   (chain_byte[i]),
          .valid_in  (chain_vld[i]),
          .sig_byte  (sig_all[8*(SIGNATURE_LENGTH-2-i) +: 8]),
          .byte_out  (chain_byte[i+1]),
          .valid_out (chain_vld[i+1]),
          .hit       (cell_hit[i])
        );
      end
    end else begin : g_nochain
      assign cell_hit = '1;
    end
  endgenerate

  assign sig_match = (&cell_hit) && (in_tdata == sig_all[8*(SIGNATURE_LENGTH-1) +: 8]);

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    full_nxt  = full_r;
    used_nxt  = used_r;
    left_nxt  = left_r;
    win_shift = 1'b0;
    pay_valid = 1'b0;
    pay_last  = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_SEARCH: begin
          if (sig_match) begin
            phase_nxt = PH_HEADER;
            hdr_nxt   = '0;
          end else begin
            win_shift = 1'b1;
          end
        end
        PH_HEADER: begin
          if (hdr_r < 3'(HDR_FIELD_BYTES)) begin
            full_nxt[{hdr_r[1:0], 3'b000} +: 8] = in_tdata;
          end else begin
            used_nxt[{hdr_r[1:0], 3'b000} +: 8] = in_tdata;
          end
          hdr_nxt = hdr_r + 3'd1;
          if (hdr_r == 3'(2 * HDR_FIELD_BYTES - 1)) begin
            left_nxt  = used_nxt;
            phase_nxt = (used_nxt == '0) ? PH_DONE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_nxt  = left_r - SIZE_W'(1);
          pay_valid = 1'b1;
          pay_last  = (left_r == SIZE_W'(1));
          if (pay_last) begin
            phase_nxt = PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_DONE:   rpt_status = ST_EXTRACTED;
      PH_SEARCH: rpt_status = ST_NOT_FOUND;
      default:   rpt_status = ST_TRUNCATED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || end_fire) begin
      phase_r <= PH_SEARCH;
      hdr_r   <= '0;
      full_r  <= '0;
      used_r  <= '0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      full_r  <= full_nxt;
      used_r  <= used_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    pay_item           = '0;
    pay_item.kind      = KIND_PAYLOAD;
    pay_item.data_byte = in_tdata;
    pay_item.last      = pay_last;

    rpt_item           = '0;
    rpt_item.kind      = KIND_REPORT;
    rpt_item.status    = rpt_status;
    if (rpt_status != ST_NOT_FOUND) begin
      rpt_item.used_size = used_nxt;
      rpt_item.full_size = full_nxt;
    end

    push.a_valid = pay_valid || end_fire;
    push.b_valid = pay_valid && end_fire;
    wr_a         = pay_valid ? pay_item : rpt_item;
    wr_b         = rpt_item;
  end

  sse_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .pop       (out_tvalid && out_tready),
    .room2     (room2),
    .not_empty (q_not_empty),
    .head      (head)
  );

  assign in_tready  = room2;
  assign out_tvalid = q_not_empty;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {6'd0, head.full_size, head.used_size, head.status, head.data_byte};

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> (phase_r == PH_SEARCH) && (hdr_r == '0) && (left_r == '0))
    else $error("state not cleared after image end");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (left_r != '0))
    else $error("payload phase with no bytes left");

  a_hdr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER) |-> (hdr_r == '0))
    else $error("header index moved outside header phase");

  a_report_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_REPORT)) |-> !out_tlast)
    else $error("report marked as last payload byte");

endmodule

// File: tb/signature_section_extractor_test.sv
// Self-checking testbench for signature_section_extractor: streams byte images
// through in_, checks every out_ transaction against an in-bench predictor.
// Depends on sse_pkg and the signature_section_extractor RTL.
module signature_section_extractor_test
  import sse_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIG_LEN       = 16;
  localparam int WIN_DEPTH     = SIG_BYTES_MAX - 1;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 150;

  typedef enum logic [1:0] {SEARCHING, IN_HEADER, IN_PAYLOAD, SECTION_DONE} parse_phase_t;
  typedef logic [7:0] octet_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [79:0]            out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  signature_section_extractor #(.SIGNATURE_LENGTH(SIG_LEN)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  // predictor state
  logic [63:0]  sig_lo;
  logic [63:0]  sig_hi;
  octet_t       win [WIN_DEPTH];
  int           win_count;
  parse_phase_t phase;
  logic [2:0]   hdr_idx;
  logic [31:0]  full_sz;
  logic [31:0]  used_sz;
  logic [31:0]  left;

  result_t expected_results[$];
  octet_t  image_buf[$];
  int      fail_count  = 0;
  int      stall_count = 0;
  int      bytes_sent  = 0;
  int      hold_cycles = 0;
  int      burst_left  = 0;
  bit      gaps_on     = 1'b1;
  bit      offering    = 1'b0;
  int      rx_mode     = 0;
  int      rx_left     = 0;

  function automatic octet_t sig_byte_at(int k);
    return (k < 8) ? sig_lo[8*k +: 8] : sig_hi[8*(k-8) +: 8];
  endfunction

  function automatic void clear_parse_state();
    foreach (win[i]) win[i] = '0;
    win_count = 0;
    phase     = SEARCHING;
    hdr_idx   = '0;
    full_sz   = '0;
    used_sz   = '0;
    left      = '0;
  endfunction

  function automatic void predict_section_results(octet_t b, logic e);
    result_t r;
    logic    hit;
    case (phase)
      SEARCHING: begin
        hit = (win_count >= SIG_LEN - 1) && (b == sig_byte_at(SIG_LEN - 1));
        for (int k = 0; k < SIG_LEN - 1; k++)
          if (win[WIN_DEPTH + 1 - SIG_LEN + k] != sig_byte_at(k)) hit = 1'b0;
        if (hit) begin
          phase   = IN_HEADER;
          hdr_idx = '0;
        end else begin
          for (int k = 0; k < WIN_DEPTH - 1; k++) win[k] = win[k+1];
          win[WIN_DEPTH-1] = b;
          if (win_count < WIN_DEPTH) win_count++;
        end
      end
      IN_HEADER: begin
        if (hdr_idx < HDR_FIELD_BYTES) full_sz[8*hdr_idx +: 8] = b;
        else used_sz[8*(hdr_idx - HDR_FIELD_BYTES) +: 8] = b;
        if (hdr_idx == 2*HDR_FIELD_BYTES - 1) begin
          left  = used_sz;
          phase = (left == 0) ? SECTION_DONE : IN_PAYLOAD;
        end
        hdr_idx++;
      end
      IN_PAYLOAD: begin
        left--;
        r           = '0;
        r.kind      = KIND_PAYLOAD;
        r.data_byte = b;
        r.last      = (left == 0);
        expected_results.push_back(r);
        if (left == 0) phase = SECTION_DONE;
      end
      default: ;
    endcase
    if (e) begin
      r      = '0;
      r.kind = KIND_REPORT;
      case (phase)
        SECTION_DONE: r.status = ST_EXTRACTED;
        SEARCHING:    r.status = ST_NOT_FOUND;
        default:      r.status = ST_TRUNCATED;
      endcase
      if (phase != SEARCHING) begin
        r.used_size = used_sz;
        r.full_size = full_sz;
      end
      expected_results.push_back(r);
      clear_parse_state();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void append_random(int n);
    repeat (n) image_buf.push_back(octet_t'($urandom));
  endfunction

  function automatic void append_signature(int n = SIG_LEN);
    for (int k = 0; k < n; k++) image_buf.push_back(sig_byte_at(k));
  endfunction

  function automatic void append_header(logic [31:0] full, logic [31:0] used, int n = 8);
    for (int k = 0; k < n; k++)
      image_buf.push_back((k < HDR_FIELD_BYTES) ? full[8*k +: 8]
                                                : used[8*(k - HDR_FIELD_BYTES) +: 8]);
  endfunction

  task automatic send_byte(octet_t b, logic e);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= e;
    offering  = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_section_results(b, e);
    bytes_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_tvalid <= 1'b0;
        offering  = 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic stop_sending();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  task automatic send_image();
    foreach (image_buf[i]) send_byte(image_buf[i], i == image_buf.size() - 1);
    image_buf.delete();
  endtask

  task automatic wait_drained();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_signature(logic [63:0] lo, logic [63:0] hi);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SIG_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_SIG_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sig_lo = lo;
    sig_hi = hi;
  endtask

  task automatic test_reset_signature();
    append_signature();
    append_header(32'h0000_0010, 32'd2);
    image_buf.push_back(8'h00);
    image_buf.push_back(8'hFF);
    send_image();
  endtask

  task automatic test_special_cases();
    logic [63:0] hi;
    hi       = {$urandom, $urandom};
    hi[7:0]  = 8'h5F;
    set_signature(64'h4853_414C_4649_5F24, hi);
    append_random(1);
    send_image();
    append_random(5);
    append_signature(SIG_LEN - 1);
    send_image();
    append_signature(SIG_LEN - 1);
    image_buf.push_back(~sig_byte_at(SIG_LEN - 1));
    append_signature();
    append_header(32'hFFFF_FFFF, 32'd3);
    image_buf.push_back(8'h00);
    image_buf.push_back(8'hFF);
    image_buf.push_back(8'hA5);
    send_image();
    append_signature();
    append_header(32'h1234_5678, 32'h9ABC_DEF0, 5);
    send_image();
    append_signature();
    send_image();
    append_random(2);
    append_signature();
    append_header(32'd0, 32'd0);
    append_random(3);
    send_image();
    append_signature();
    append_header(32'h8000_0001, 32'hFFFF_FFFF);
    append_random(4);
    send_image();
    append_signature();
    append_header($urandom, 32'd20);
    append_signature();
    append_random(4);
    append_signature();
    append_random(3);
    send_image();
  endtask

  task automatic test_backpressure();
    wait_drained();
    gaps_on     = 1'b0;
    hold_cycles = HOLD_CYCLES;
    append_signature();
    append_header(32'd7, 32'd40);
    append_random(40);
    send_image();
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_traffic(logic [63:0] lo, logic [63:0] hi, int n);
    int          stop_at;
    int          sel;
    int          k;
    int          hdr_n;
    logic [31:0] used;
    set_signature(lo, hi);
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        append_random($urandom_range(1, 40));
      end else if (sel == 1) begin
        k = $urandom_range(1, SIG_LEN - 1);
        append_signature(k);
        image_buf.push_back(~sig_byte_at(k));
        append_random($urandom_range(0, 10));
      end else begin
        append_random($urandom_range(0, 12));
        if ($urandom_range(0, 3) == 0) append_signature($urandom_range(1, SIG_LEN - 1));
        append_signature();
        case ($urandom_range(0, 9))
          0:       used = 32'd0;
          1:       used = $urandom;
          default: used = $urandom_range(1, 16);
        endcase
        hdr_n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
        append_header($urandom, used, hdr_n);
        if (hdr_n == 8) begin
          if (used > 16) append_random($urandom_range(0, 12));
          else if ($urandom_range(0, 7) == 0) append_random($urandom_range(0, used));
          else begin
            append_random(used);
            append_random($urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0) begin
              append_signature();
              append_random(1);
            end
          end
        end
      end
      send_image();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: item_kind %0d payload_byte %0h status %0d",
               out_tuser, out_tdata[7:0], out_tdata[9:8]);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_kind", want.kind, out_tuser);
        check_field("payload_byte", want.data_byte, out_tdata[7:0]);
        check_field("payload_last", want.last, out_tlast);
        check_field("status", want.status, out_tdata[9:8]);
        check_field("declared_used_size", want.used_size, out_tdata[41:10]);
        check_field("declared_full_size", want.full_size, out_tdata[73:42]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_count = 0;
    else stall_count++;
    if (stall_count >= IDLE_LIMIT) begin
      $display("signature_section_extractor verification failed");
      $finish;
    end
  end

  initial begin
    sig_lo = '0;
    sig_hi = '0;
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_signature();
    test_special_cases();
    test_backpressure();
    test_random_traffic('1, '1, 170);
    test_random_traffic({$urandom, $urandom}, {$urandom, $urandom}, 170);
    test_random_traffic({8{8'h3C}}, {8'hBC, {7{8'h3C}}}, 170);
    test_random_traffic('0, '0, 170);
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("signature_section_extractor verification clean");
    end else begin
      $display("signature_section_extractor verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/sse_pkg.sv
design/sse_cell.sv
design/sse_result_fifo.sv
design/signature_section_extractor.sv
tb/signature_section_extractor_test.sv
